### src/atfh_pkg.sv
// atfh_pkg: types, widths and register codes for the atom triple fingerprint hash
// used by atom_triple_fingerprint_hash; depends on nothing else
package atfh_pkg;

  localparam int TYPE_BITS = 24;
  localparam int DIST_BITS = 8;

  // comparison width for distances against the 8-bit limits
  localparam int CMPW = (DIST_BITS > 8) ? DIST_BITS : 8;
  // side sum and triangle terms
  localparam int SW   = DIST_BITS + 2;
  localparam int TW   = DIST_BITS + 1;
  localparam int XW   = SW + TW;
  localparam int YW   = 2 * TW;
  // sixteen times squared area, padded to an even width
  localparam int QW   = 4 * DIST_BITS + 6;
  localparam int RW1  = QW / 2;
  localparam int RW2  = DIST_BITS + 2;
  localparam int RMW  = RW1 + 2;
  localparam int NR   = RW1 + RW2;

  // register indexes
  localparam logic [2:0] CFG_MIN_DIST      = 3'd0;
  localparam logic [2:0] CFG_MAX_DIST      = 3'd1;
  localparam logic [2:0] CFG_ALLOW_LINEAR  = 3'd2;
  localparam logic [2:0] CFG_AREA_MODE     = 3'd3;
  localparam logic [2:0] CFG_CANONICALISE  = 3'd4;
  localparam logic [2:0] CFG_TRIANGLE_MODE = 3'd5;
  localparam logic [2:0] CFG_ADDITIVE_HASH = 3'd6;

  // reorder codes for the canonical edge
  localparam logic [2:0] RO_NONE = 3'd0;
  localparam logic [2:0] RO_IK   = 3'd1;
  localparam logic [2:0] RO_IJ   = 3'd2;
  localparam logic [2:0] RO_TIK  = 3'd3;
  localparam logic [2:0] RO_TIJ  = 3'd4;

  typedef struct packed {
    logic [TYPE_BITS-1:0] type_a;
    logic [TYPE_BITS-1:0] type_b;
    logic [TYPE_BITS-1:0] type_c;
    logic [DIST_BITS-1:0] dist_ab;
    logic [DIST_BITS-1:0] dist_ac;
    logic [DIST_BITS-1:0] dist_bc;
  } atfh_in_t;

  typedef struct packed {
    logic [31:0] bit_number;
    logic [7:0]  hit_count;
  } atfh_out_t;

  // state of the digit-by-digit square root
  typedef struct packed {
    logic [QW-1:0]  q;
    logic [RMW-1:0] rem;
    logic [RW1-1:0] root;
  } atfh_rt_t;

  // one result bit of the restoring square root
  function automatic atfh_rt_t atfh_sqrt_step(atfh_rt_t st);
    atfh_rt_t       res;
    logic [RMW-1:0] rem_sh;
    logic [RMW-1:0] trial;
    rem_sh = {st.rem[RMW-3:0], st.q[QW-1:QW-2]};
    trial  = {st.root, 2'b01};
    res.q  = {st.q[QW-3:0], 2'b00};
    if (rem_sh >= trial) begin
      res.rem  = rem_sh - trial;
      res.root = {st.root[RW1-2:0], 1'b1};
    end else begin
      res.rem  = rem_sh;
      res.root = {st.root[RW1-2:0], 1'b0};
    end
    return res;
  endfunction

endpackage

### src/atom_triple_fingerprint_hash.sv
// atom_triple_fingerprint_hash: filter, canonical reorder, hashing and area count
// depends on atfh_pkg
//
// Usage: one atom triple request enters on in_data when in_valid is high and in_stall
// low. A kept triple leaves as one result (bit_number, hit_count) on out_data with
// out_valid; a triple dropped by the distance filter, or of zero or impossible area
// in area mode, gives no result. Configuration is written through cfg_we, cfg_idx
// and cfg_wdata while the block is idle.
// Throughput: one request per cycle while in_stall is low. Order is kept: every request
// passes stages 1 to 4, the square root chain of the area count (one result bit per
// stage, NR = 3*DIST_BITS + 5 bits, 29 for 8-bit distances) and the output register.
// Reset (rst_n low, synchronous) empties the pipeline and restores the register
// defaults. When the receiver stalls a held result, the whole pipeline freezes and
// in_stall rises in the same cycle; nothing is lost or repeated.
module atom_triple_fingerprint_hash
  import atfh_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_idx,
  input  logic [7:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  atfh_in_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output atfh_out_t   out_data
);

  // configuration registers
  logic [7:0] min_dist_r, max_dist_r;
  logic       allow_linear_r, area_mode_r, canon_r, tri_r, add_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_dist_r     <= 8'd0;
      max_dist_r     <= 8'd255;
      allow_linear_r <= 1'b1;
      area_mode_r    <= 1'b0;
      canon_r        <= 1'b1;
      tri_r          <= 1'b0;
      add_r          <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_MIN_DIST:      min_dist_r     <= cfg_wdata;
        CFG_MAX_DIST:      max_dist_r     <= cfg_wdata;
        CFG_ALLOW_LINEAR:  allow_linear_r <= cfg_wdata[0];
        CFG_AREA_MODE:     area_mode_r    <= cfg_wdata[0];
        CFG_CANONICALISE:  canon_r        <= cfg_wdata[0];
        CFG_TRIANGLE_MODE: tri_r          <= cfg_wdata[0];
        CFG_ADDITIVE_HASH: add_r          <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // global advance: move when the output slot is free or being taken
  logic adv;
  logic out_valid_r;
  atfh_out_t out_data_r;
  assign adv       = !out_valid_r || !out_stall;
  assign in_stall  = !adv;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // stage 1: distance filter, area terms and canonical reorder
  logic [DIST_BITS-1:0] dij, dik, djk;
  logic [TW-1:0]        sij, sik, sjk;
  logic                 lin_hit, max_hit, min_hit, area_ok, keep;
  logic [TYPE_BITS:0]   eij, eik, ejk;
  logic [2:0]           ro;
  logic [TYPE_BITS-1:0] ri, rj, rk;
  logic [DIST_BITS-1:0] rij, rik, rjk;
  logic [SW-1:0]        s_sum;

  assign dij   = in_data.dist_ab;
  assign dik   = in_data.dist_ac;
  assign djk   = in_data.dist_bc;
  assign sij   = TW'(dij) + TW'(dik);
  assign sik   = TW'(dij) + TW'(djk);
  assign sjk   = TW'(dik) + TW'(djk);
  assign s_sum = SW'(dij) + SW'(dik) + SW'(djk);
  assign eij   = (TYPE_BITS+1)'(in_data.type_a) + (TYPE_BITS+1)'(in_data.type_b);
  assign eik   = (TYPE_BITS+1)'(in_data.type_a) + (TYPE_BITS+1)'(in_data.type_c);
  assign ejk   = (TYPE_BITS+1)'(in_data.type_b) + (TYPE_BITS+1)'(in_data.type_c);

  always_comb begin
    lin_hit = (sij == TW'(djk)) || (sik == TW'(dik)) || (sjk == TW'(dij));
    max_hit = (CMPW'(dij) > CMPW'(max_dist_r)) || (CMPW'(dik) > CMPW'(max_dist_r)) ||
              (CMPW'(djk) > CMPW'(max_dist_r));
    min_hit = (min_dist_r != 8'd0) &&
              ((CMPW'(dij) < CMPW'(min_dist_r)) || (CMPW'(dik) < CMPW'(min_dist_r)) ||
               (CMPW'(djk) < CMPW'(min_dist_r)));
    area_ok = (sjk > TW'(dij)) && (sik > TW'(dik)) && (sij > TW'(djk));
    keep    = !(lin_hit && !allow_linear_r) && !max_hit && !min_hit &&
              (!area_mode_r || area_ok);
  end

  // canonical edge choice, longest unique side first
  always_comb begin
    if (djk > dij && djk > dik)                         ro = RO_NONE;
    else if (dij > dik && dij > djk)                    ro = RO_IK;
    else if (dik > dij && dik > djk)                    ro = RO_IJ;
    else if (djk < dik && djk < dij)                    ro = RO_NONE;
    else if (dij < dik && dij < djk)                    ro = RO_IK;
    else if (dik < dij && dik < djk)                    ro = RO_IJ;
    else if (in_data.type_b == in_data.type_c)          ro = RO_NONE;
    else if (in_data.type_a == in_data.type_b)          ro = RO_IK;
    else if (in_data.type_a == in_data.type_c)          ro = RO_IJ;
    else if (ejk < eij && ejk < eik)                    ro = RO_NONE;
    else if (eij < eik && eij < ejk)                    ro = RO_TIK;
    else if (eik < eij && eik < ejk)                    ro = RO_TIJ;
    else                                                ro = RO_NONE;
  end

  always_comb begin
    ri = in_data.type_a; rj = in_data.type_b; rk = in_data.type_c;
    rij = dij; rik = dik; rjk = djk;
    unique case (ro)
      RO_IK: begin
        ri = in_data.type_c; rk = in_data.type_a; rij = djk; rjk = dij;
      end
      RO_IJ: begin
        ri = in_data.type_b; rj = in_data.type_a; rik = djk; rjk = dik;
      end
      RO_TIK: begin
        ri = in_data.type_c; rk = in_data.type_a;
      end
      RO_TIJ: begin
        ri = in_data.type_b; rj = in_data.type_a;
      end
      default: ;
    endcase
  end

  logic                 s1_vld_r;
  logic [31:0]          s1_ti_r, s1_tj_r, s1_tk_r;
  logic [31:0]          s1_dij_r, s1_dik_r, s1_djk_r;
  logic [SW-1:0]        s1_s_r;
  logic [TW-1:0]        s1_t1_r, s1_t2_r, s1_t3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= in_valid && keep;
      s1_ti_r  <= 32'(ri);
      s1_tj_r  <= 32'(rj);
      s1_tk_r  <= 32'(rk);
      s1_dij_r <= 32'(rij);
      s1_dik_r <= 32'(rik);
      s1_djk_r <= 32'(rjk);
      s1_s_r   <= s_sum;
      s1_t1_r  <= TW'(s_sum - {dij, 1'b0});
      s1_t2_r  <= TW'(s_sum - {dik, 1'b0});
      s1_t3_r  <= TW'(s_sum - {djk, 1'b0});
    end
  end

  // stage 2: constant products, additive hashes and area factors
  logic [31:0] tsum, dsum3, dsum2;
  logic [31:0] b_simple;
  assign tsum  = s1_ti_r + s1_tj_r + s1_tk_r;
  assign dsum3 = s1_dij_r + s1_dik_r + s1_djk_r;
  assign dsum2 = s1_dij_r + s1_dik_r;

  always_comb begin
    if (area_mode_r)             b_simple = tsum;
    else if (tri_r)              b_simple = tsum + 32'd910 * dsum3;
    else if (!canon_r)           b_simple = tsum + 32'd5121 * dsum2;
    else                         b_simple = tsum + (s1_ti_r << 2) - s1_ti_r
                                            + 32'd5121 * dsum2;
  end

  logic              s2_vld_r;
  logic [31:0]       s2_p1_r, s2_p2_r, s2_p3_r, s2_m1_r, s2_m2_r, s2_m3_r;
  logic [31:0]       s2_bs_r, s2_dij_r, s2_dik_r, s2_d23_r, s2_dmix_r;
  logic [XW-1:0]     s2_x_r;
  logic [YW-1:0]     s2_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (adv) begin
      s2_vld_r  <= s1_vld_r;
      s2_p1_r   <= 32'd1421021 * s1_ti_r;
      s2_p2_r   <= 32'd71212 * s1_tj_r;
      s2_p3_r   <= 32'd13111 * s1_tk_r;
      s2_m1_r   <= 32'd11 * s1_ti_r;
      s2_m2_r   <= 32'd111 * s1_tj_r;
      s2_m3_r   <= 32'd2012 * s1_tk_r;
      s2_bs_r   <= b_simple;
      s2_dij_r  <= s1_dij_r;
      s2_dik_r  <= s1_dik_r;
      s2_d23_r  <= 32'd23 * s1_djk_r;
      s2_dmix_r <= s1_dij_r + 32'd29 * s1_dik_r;
      s2_x_r    <= XW'(s1_s_r) * XW'(s1_t1_r);
      s2_y_r    <= YW'(s1_t2_r) * YW'(s1_t3_r);
    end
  end

  // stage 3: weighted type sums and the area product
  logic          s3_vld_r;
  logic [31:0]   s3_a_r, s3_bm_r, s3_bs_r, s3_dik_r, s3_d23_r, s3_dmix_r;
  logic [QW-1:0] s3_q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else if (adv) begin
      s3_vld_r  <= s2_vld_r;
      s3_a_r    <= s2_p1_r + s2_p2_r + s2_p3_r + s2_dij_r;
      s3_bm_r   <= s2_m1_r + s2_m2_r + s2_m3_r;
      s3_bs_r   <= s2_bs_r;
      s3_dik_r  <= s2_dik_r;
      s3_d23_r  <= s2_d23_r;
      s3_dmix_r <= s2_dmix_r;
      s3_q_r    <= QW'(s2_x_r) * QW'(s2_y_r);
    end
  end

  // stage 4: multiplicative hashes and final bit number
  logic        use_tri_mul, use_plain_mul;
  logic [31:0] b_fin;
  assign use_tri_mul   = !area_mode_r && canon_r && tri_r && !add_r;
  assign use_plain_mul = !area_mode_r && !canon_r && !tri_r && !add_r;

  always_comb begin
    if (use_tri_mul)        b_fin = s3_a_r * s3_dik_r + s3_d23_r;
    else if (use_plain_mul) b_fin = s3_bm_r * s3_dmix_r;
    else                    b_fin = s3_bs_r;
  end

  logic          s4_vld_r;
  logic [31:0]   s4_b_r;
  logic [QW-1:0] s4_q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else if (adv) begin
      s4_vld_r <= s3_vld_r;
      s4_b_r   <= b_fin;
      s4_q_r   <= s3_q_r;
    end
  end

  // square root chain: square root of q, then square root of that root
  logic        rt_vld_r [NR];
  logic [31:0] rt_b_r   [NR];
  atfh_rt_t    rt_st_r  [NR];

  for (genvar k = 0; k < NR; k++) begin : g_root
    atfh_rt_t st_in;
    logic     vld_in;
    logic [31:0] b_in;

    if (k == 0) begin : g_first
      always_comb begin
        vld_in      = s4_vld_r;
        b_in        = s4_b_r;
        st_in.q     = s4_q_r;
        st_in.rem   = '0;
        st_in.root  = '0;
      end
    end else if (k == RW1) begin : g_second
      always_comb begin
        vld_in      = rt_vld_r[k-1];
        b_in        = rt_b_r[k-1];
        st_in.q     = {(2*RW2)'(rt_st_r[k-1].root), (QW-2*RW2)'(0)};
        st_in.rem   = '0;
        st_in.root  = '0;
      end
    end else begin : g_mid
      always_comb begin
        vld_in      = rt_vld_r[k-1];
        b_in        = rt_b_r[k-1];
        st_in       = rt_st_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        rt_vld_r[k] <= 1'b0;
      end else if (adv) begin
        rt_vld_r[k] <= vld_in;
        rt_b_r[k]   <= b_in;
        rt_st_r[k]  <= atfh_sqrt_step(st_in);
      end
    end
  end

  // output register: count from the fourth root, saturated; one outside area mode
  logic [RW2-1:0] r4, cnt;
  logic [7:0]     hit;
  assign r4  = RW2'(rt_st_r[NR-1].root);
  assign cnt = (r4 >> 1) + RW2'(1);
  assign hit = !area_mode_r ? 8'd1 : ((cnt > RW2'(255)) ? 8'd255 : 8'(cnt));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r           <= rt_vld_r[NR-1];
      out_data_r.bit_number <= rt_b_r[NR-1];
      out_data_r.hit_count  <= hit;
    end
  end

  // checks
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled with free output slot");

  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.hit_count != 8'd0))
    else $error("zero hit count emitted");

  a_count_one_outside_area: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !area_mode_r) |-> (out_data.hit_count == 8'd1))
    else $error("count other than one outside area mode");

  a_empty_after_reset: assert property (@(posedge clk)
    (rst_n && $past(!rst_n)) |-> !out_valid)
    else $error("result present straight after reset");

endmodule

### dv/atom_triple_fingerprint_hash_tb.sv
// atom_triple_fingerprint_hash_tb: self-checking bench for the atom triple fingerprint hash
// depends on atfh_pkg and atom_triple_fingerprint_hash; predicts each triple's hash and count
module atom_triple_fingerprint_hash_tb;
  import atfh_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // register copy plus queue of predicted fingerprint hits
  class hit_scoreboard;
    logic [7:0] min_d, max_d;
    bit lin_ok, area_on, canon_on, tri_on, add_on;
    atfh_out_t pending[$];
    int errors;

    function void set_reg(logic [2:0] idx, logic [7:0] val);
      case (idx)
        CFG_MIN_DIST:      min_d = val;
        CFG_MAX_DIST:      max_d = val;
        CFG_ALLOW_LINEAR:  lin_ok = val[0];
        CFG_AREA_MODE:     area_on = val[0];
        CFG_CANONICALISE:  canon_on = val[0];
        CFG_TRIANGLE_MODE: tri_on = val[0];
        CFG_ADDITIVE_HASH: add_on = val[0];
        default: ;
      endcase
    endfunction

    // reorder so the canonical edge lies between atoms j and k
    function void reorder(ref logic [31:0] ti, tj, tk, dij, dik, djk);
      logic [31:0] t;
      logic [33:0] eij, eik, ejk;
      bit sw_ik, sw_ij;
      sw_ik = 0;
      sw_ij = 0;
      eij = ti + tj;
      eik = ti + tk;
      ejk = tj + tk;
      if (djk > dij && djk > dik) ;
      else if (dij > dik && dij > djk) begin
        t = dij; dij = djk; djk = t; sw_ik = 1;
      end else if (dik > dij && dik > djk) begin
        t = dik; dik = djk; djk = t; sw_ij = 1;
      end else if (djk < dik && djk < dij) ;
      else if (dij < dik && dij < djk) begin
        t = dij; dij = djk; djk = t; sw_ik = 1;
      end else if (dik < dij && dik < djk) begin
        t = dik; dik = djk; djk = t; sw_ij = 1;
      end else if (tj == tk) ;
      else if (ti == tj) begin
        t = dij; dij = djk; djk = t; sw_ik = 1;
      end else if (ti == tk) begin
        t = dik; dik = djk; djk = t; sw_ij = 1;
      end else if (ejk < eij && ejk < eik) ;
      else if (eij < eik && eij < ejk) sw_ik = 1;
      else if (eik < eij && eik < ejk) sw_ij = 1;
      if (sw_ik) begin t = ti; ti = tk; tk = t; end
      if (sw_ij) begin t = ti; ti = tj; tj = t; end
    endfunction

    function void note_request(atfh_in_t req);
      logic [31:0] ti, tj, tk, dij, dik, djk, b;
      longint s, t1, t2, t3, q, r, c;
      int cnt;
      ti = req.type_a; tj = req.type_b; tk = req.type_c;
      dij = req.dist_ab; dik = req.dist_ac; djk = req.dist_bc;
      cnt = 1;
      if (!lin_ok && (dij + dik == djk || dij + djk == dik || dik + djk == dij)) return;
      if (dij > max_d || dik > max_d || djk > max_d) return;
      if (min_d != 0 && (dij < min_d || dik < min_d || djk < min_d)) return;
      if (area_on) begin
        s = dij + dik + djk;
        t1 = s - 2 * dij; t2 = s - 2 * dik; t3 = s - 2 * djk;
        if (t1 <= 0 || t2 <= 0 || t3 <= 0) return;
        q = s * t1 * t2 * t3;
        r = 0;
        for (int i = 18; i >= 0; i--) begin
          c = r | (64'd1 << i);
          if (c * c <= 64'd4294967295 && c * c * c * c <= q) r = c;
        end
        cnt = int'(r / 2 + 1);
        if (cnt > 255) cnt = 255;
        b = ti + tj + tk;
      end else if (!canon_on && tri_on) begin
        b = (ti + tj + tk) + 32'd910 * (dij + dik + djk);
      end else begin
        reorder(ti, tj, tk, dij, dik, djk);
        if (!canon_on) begin
          if (add_on) b = (ti + tj + tk) + 32'd5121 * (dij + dik);
          else b = (32'd11 * ti + 32'd111 * tj + 32'd2012 * tk) * (dij + 32'd29 * dik);
        end else if (tri_on) begin
          if (add_on) b = (ti + tj + tk) + 32'd910 * (dij + dik + djk);
          else b = (32'd1421021 * ti + 32'd71212 * tj + 32'd13111 * tk + dij) * dik
                   + 32'd23 * djk;
        end else begin
          b = (32'd4 * ti + tj + tk) + 32'd5121 * (dij + dik);
        end
      end
      pending.push_back('{bit_number: b, hit_count: cnt[7:0]});
    endfunction

    function void check_hit(atfh_out_t got);
      atfh_out_t exp_hit;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected hit, expected none, actual %h/%0d", $realtime,
                 got.bit_number, got.hit_count);
        return;
      end
      exp_hit = pending.pop_front();
      if (got.bit_number !== exp_hit.bit_number) begin
        errors++;
        $display("%0t: bit_number expected %h actual %h", $realtime,
                 exp_hit.bit_number, got.bit_number);
      end
      if (got.hit_count !== exp_hit.hit_count) begin
        errors++;
        $display("%0t: hit_count expected %0d actual %0d", $realtime,
                 exp_hit.hit_count, got.hit_count);
      end
    endfunction
  endclass

  localparam int LATENCY = 5 + NR;

  logic clk = 0, rst_n = 0;
  logic cfg_we = 0;
  logic [2:0] cfg_idx = '0;
  logic [7:0] cfg_wdata = '0;
  logic in_valid = 0, out_stall = 0;
  atfh_in_t in_data = '0;
  logic in_stall, out_valid;
  atfh_out_t out_data;

  int send_idle = 0, recv_stall = 0, hold_cycles = 0;
  hit_scoreboard sb;

  always #1 clk = ~clk;

  atom_triple_fingerprint_hash dut (.*);

  // sample results at the rising edge
  always @(posedge clk)
    if (rst_n && out_valid && !out_stall) sb.check_hit(out_data);

  // receiver stall, with a long hold-off when asked
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall);
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [7:0] val);
    cfg_we <= 1; cfg_idx <= idx; cfg_wdata <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
    @(negedge clk);
    cfg_we <= 0;
    @(negedge clk);
  endtask

  // offer one request and hold it until taken
  task automatic send_request(atfh_in_t req);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    in_data <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(req);
    @(negedge clk);
  endtask

  task automatic drain;
    in_valid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (LATENCY + 5) @(negedge clk);
  endtask

  function automatic logic [7:0] rand_dist();
    case ($urandom_range(5))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'($urandom_range(1, 8));
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic atfh_in_t rand_triple();
    atfh_in_t r;
    r.type_a = 24'($urandom); r.type_b = 24'($urandom); r.type_c = 24'($urandom);
    if ($urandom_range(3) == 0) begin
      r.type_a = 24'($urandom_range(3));
      r.type_b = 24'($urandom_range(3));
      r.type_c = 24'($urandom_range(3));
    end
    r.dist_ab = rand_dist(); r.dist_ac = rand_dist(); r.dist_bc = rand_dist();
    case ($urandom_range(5))
      0: begin r.dist_ac = r.dist_ab; r.dist_bc = r.dist_ab; end
      1: r.dist_bc = r.dist_ab;
      2: r.dist_bc = r.dist_ab + r.dist_ac;
      default: ;
    endcase
    return r;
  endfunction

  task automatic directed_set;
    atfh_in_t r;
    int d[20][3] = '{'{0,0,0}, '{255,255,255}, '{3,4,5}, '{3,4,7}, '{5,5,5},
                     '{9,2,2}, '{2,9,2}, '{2,2,9}, '{200,100,150}, '{10,10,20},
                     '{1,1,1}, '{255,1,255}, '{7,3,3}, '{3,7,3}, '{3,3,7},
                     '{128,127,255}, '{4,4,4}, '{6,6,6}, '{255,0,255}, '{50,60,70}};
    for (int i = 0; i < 20; i++) begin
      r.type_a = (i % 4 == 0) ? 24'hFFFFFF : (i % 4 == 1) ? 24'd0 : 24'(5 + i);
      r.type_b = (i % 3 == 0) ? r.type_a : 24'd9;
      r.type_c = (i % 5 == 0) ? 24'hFFFFFF : 24'(3 + i % 2);
      r.dist_ab = 8'(d[i][0]); r.dist_ac = 8'(d[i][1]); r.dist_bc = 8'(d[i][2]);
      send_request(r);
    end
  endtask

  initial begin
    sb = new();
    sb.errors = 0;
    sb.min_d = 0; sb.max_d = 255; sb.lin_ok = 1; sb.area_on = 0;
    sb.canon_on = 1; sb.tri_on = 0; sb.add_on = 0;
    repeat (4) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // directed pass in every hash mode
    for (int m = 0; m < 6; m++) begin
      write_reg(CFG_AREA_MODE, 8'(m == 5));
      write_reg(CFG_CANONICALISE, 8'(m[0]));
      write_reg(CFG_TRIANGLE_MODE, 8'(m[1]));
      write_reg(CFG_ADDITIVE_HASH, 8'(m[2] | (m == 4)));
      directed_set();
      drain();
    end

    // random phases through settings and idling profiles
    for (int ph = 0; ph < 16; ph++) begin
      case (ph % 4)
        0: begin send_idle = 0; recv_stall = 0; end
        1: begin send_idle = 69; recv_stall = 0; end
        2: begin send_idle = 0; recv_stall = 69; end
        default: begin send_idle = 20; recv_stall = 20; end
      endcase
      write_reg(CFG_MIN_DIST, (ph % 5 == 0) ? 8'd0 : (ph % 5 == 1) ? 8'd255 :
                8'($urandom_range(0, 20)));
      write_reg(CFG_MAX_DIST, (ph % 7 == 3) ? 8'd0 : (ph % 3 == 0) ? 8'd255 :
                8'($urandom_range(100, 255)));
      write_reg(CFG_ALLOW_LINEAR, 8'(ph[0]));
      write_reg(CFG_AREA_MODE, 8'((ph % 3) == 2));
      write_reg(CFG_CANONICALISE, 8'(ph[1]));
      write_reg(CFG_TRIANGLE_MODE, 8'(ph[2]));
      write_reg(CFG_ADDITIVE_HASH, 8'(ph[3]));
      if (ph == 4) hold_cycles <= 200;
      for (int i = 0; i < 90; i++) send_request(rand_triple());
      drain();
    end

    // restore the reset settings for a last stretch
    write_reg(CFG_MIN_DIST, 8'd0);
    write_reg(CFG_MAX_DIST, 8'd255);
    write_reg(CFG_ALLOW_LINEAR, 8'd1);
    write_reg(CFG_AREA_MODE, 8'd0);
    write_reg(CFG_CANONICALISE, 8'd1);
    write_reg(CFG_TRIANGLE_MODE, 8'd0);
    write_reg(CFG_ADDITIVE_HASH, 8'd0);
    send_idle = 20; recv_stall = 20;
    for (int i = 0; i < 10; i++) send_request(rand_triple());
    drain();

    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  // watchdog
  initial begin
    #400000;
    $display("*** FAILED ***");
    $finish;
  end
endmodule

### sim.f
src/atfh_pkg.sv
src/atom_triple_fingerprint_hash.sv
dv/atom_triple_fingerprint_hash_tb.sv
